[hdl/unsorted_range_finder_defines.svh]
// assertion macros for the unsorted range finder
// included by the top level; no other dependencies
`ifndef UNSORTED_RANGE_FINDER_DEFINES_SVH
`define UNSORTED_RANGE_FINDER_DEFINES_SVH
`ifndef SYNTHESIS
`define URF_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("%m: implication check failed");
`define URF_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("%m: next-cycle check failed");
`else
`define URF_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define URF_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

[hdl/urf_pkg.sv]
// shared types and constants for the unsorted range finder
// no dependencies
`default_nettype none
package urf_pkg;

    localparam int INDEX_BITS = 12;

    typedef struct packed {
        logic load;
        logic close;
        logic scan;
        logic post;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic can_post;
    } t_sts;

endpackage
`default_nettype wire

[hdl/urf_ram.sv]
// generic simple ram: one write port, two registered read ports
// no dependencies
`default_nettype none
module urf_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

[hdl/urf_ctrl.sv]
// controller: load phase, scan phase and result hand-off
// depends on urf_pkg
`default_nettype none
module urf_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic           i_last_item,
    output logic                o_ready,
    input  wire urf_pkg::t_sts  i_sts,
    output urf_pkg::t_cmd       o_cmd
);
    import urf_pkg::*;

    typedef enum logic [1:0] {
        S_LOAD = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_ready      = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            S_LOAD: begin
                o_ready     = 1'b1;
                o_cmd.load  = i_valid;
                o_cmd.close = i_valid && i_last_item;
                if (i_valid && i_last_item) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done && i_sts.can_post) begin
                    o_cmd.post = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

[hdl/urf_dp.sv]
// datapath: element store, load counter, two-way scan and result register
// depends on urf_pkg and urf_ram
`default_nettype none
module urf_dp #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int VALUE_BITS   = 20
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire urf_pkg::t_cmd                   i_cmd,
    output urf_pkg::t_sts                        o_sts,
    input  wire logic [VALUE_BITS-1:0]           i_value,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic                                 o_already_sorted,
    output logic      [urf_pkg::INDEX_BITS-1:0]  o_first_index,
    output logic      [urf_pkg::INDEX_BITS-1:0]  o_last_index,
    output logic                                 o_overflow
);
    import urf_pkg::*;

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int XW = (AW > INDEX_BITS) ? AW : INDEX_BITS;
    localparam logic [CW-1:0] CAP = CW'(MAX_ELEMENTS);

    logic [CW-1:0]         r_count;
    logic                  r_ovf;
    logic [CW-1:0]         r_len;
    logic                  r_len_ovf;
    logic [CW-1:0]         r_issue;
    logic                  r_rd_vld;
    logic                  r_rd_first;
    logic [AW-1:0]         r_fidx;
    logic [AW-1:0]         r_bidx;
    logic [VALUE_BITS-1:0] r_run_max;
    logic [VALUE_BITS-1:0] r_run_min;
    logic                  r_found;
    logic [AW-1:0]         r_first;
    logic [AW-1:0]         r_last;
    logic                  r_out_vld;

    logic                  w_room;
    logic                  w_issue_go;
    logic [CW-1:0]         w_baddr;
    logic [VALUE_BITS-1:0] w_fdata;
    logic [VALUE_BITS-1:0] w_bdata;
    logic [XW-1:0]         w_first_x;
    logic [XW-1:0]         w_last_x;

    assign w_room     = (r_count != CAP);
    assign w_issue_go = i_cmd.scan && (r_issue != r_len);
    assign w_baddr    = r_len - r_issue - CW'(1);
    assign w_first_x  = XW'(r_first);
    assign w_last_x   = XW'(r_last);

    urf_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (i_cmd.load && w_room),
        .i_waddr   (r_count[AW-1:0]),
        .i_wdata   (i_value),
        .i_raddr_a (r_issue[AW-1:0]),
        .o_rdata_a (w_fdata),
        .i_raddr_b (w_baddr[AW-1:0]),
        .o_rdata_b (w_bdata)
    );

    // load counter and sequence close
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_len     <= '0;
            r_len_ovf <= 1'b0;
        end else if (i_cmd.load) begin
            if (i_cmd.close) begin
                r_count   <= '0;
                r_ovf     <= 1'b0;
                r_len     <= w_room ? r_count + CW'(1) : r_count;
                r_len_ovf <= r_ovf || !w_room;
            end else if (w_room) begin
                r_count <= r_count + CW'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // read issue, forward and backward at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_issue_go;
            if (i_cmd.close) begin
                r_issue <= '0;
            end else if (w_issue_go) begin
                r_issue <= r_issue + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_first <= (r_issue == '0);
        r_fidx     <= r_issue[AW-1:0];
        r_bidx     <= w_baddr[AW-1:0];
    end

    // running max from the left, running min from the right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.close) begin
            r_found <= 1'b0;
        end else if (r_rd_vld && !r_rd_first && (w_fdata < r_run_max)) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.close) begin
            r_first <= '0;
            r_last  <= '0;
        end else if (r_rd_vld) begin
            if (r_rd_first) begin
                r_run_max <= w_fdata;
                r_run_min <= w_bdata;
            end else begin
                if (w_fdata < r_run_max) begin
                    r_last <= r_fidx;
                end else begin
                    r_run_max <= w_fdata;
                end
                if (w_bdata > r_run_min) begin
                    r_first <= r_bidx;
                end else begin
                    r_run_min <= w_bdata;
                end
            end
        end
    end

    assign o_sts.scan_done = (r_issue == r_len) && !r_rd_vld;
    assign o_sts.can_post  = !r_out_vld || i_out_ready;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.post) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            o_already_sorted <= !r_found;
            o_first_index    <= r_found ? w_first_x[INDEX_BITS-1:0] : '0;
            o_last_index     <= r_found ? w_last_x[INDEX_BITS-1:0] : '0;
            o_overflow       <= r_len_ovf;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule
`default_nettype wire

[hdl/unsorted_range_finder.sv]
// top level of the unsorted range finder: controller plus datapath
// depends on urf_pkg, urf_ctrl, urf_dp and unsorted_range_finder_defines.svh
//
// input channel (i_valid / o_ready): one word per element, i_last_item closes
// the sequence. elements load at one per cycle into the element store while
// o_ready is high. elements past MAX_ELEMENTS are dropped and flagged as
// overflow; a dropped word carrying i_last_item still closes the sequence.
// after the closing word o_ready drops while the stored sequence is scanned:
// both ram read ports sweep at once, left to right for the running maximum
// and right to left for the running minimum, one element per cycle.
// the result word is posted to the output register once every stored element
// has been read from both ends and compared.
// output channel (o_valid / i_ready): the result sits in an output register;
// loading of the next sequence goes on while it waits. if the receiver still
// stalls when the next scan ends, the block holds o_ready low until the old
// result is taken.
// reset empties the sequence, clears overflow and drops o_valid; the store
// itself is not cleared.
`default_nettype none
`include "unsorted_range_finder_defines.svh"
module unsorted_range_finder #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int VALUE_BITS   = 20
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [VALUE_BITS-1:0]           i_value,
    input  wire logic                            i_last_item,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic                                 o_already_sorted,
    output logic      [urf_pkg::INDEX_BITS-1:0]  o_first_index,
    output logic      [urf_pkg::INDEX_BITS-1:0]  o_last_index,
    output logic                                 o_overflow
);
    import urf_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    urf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last_item (i_last_item),
        .o_ready     (o_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    urf_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_value          (i_value),
        .i_out_ready      (i_ready),
        .o_out_valid      (o_valid),
        .o_already_sorted (o_already_sorted),
        .o_first_index    (o_first_index),
        .o_last_index     (o_last_index),
        .o_overflow       (o_overflow)
    );

    `URF_ASSERT_IMPLY(a_sorted_zero, i_clk, i_rst_n, o_valid && o_already_sorted, (o_first_index == '0) && (o_last_index == '0))
    `URF_ASSERT_NEXT(a_close_busy, i_clk, i_rst_n, i_valid && o_ready && i_last_item, !o_ready)
    `URF_ASSERT_IMPLY(a_post_free, i_clk, i_rst_n, w_cmd.post, !o_valid || i_ready)
    `URF_ASSERT_NEXT(a_post_shown, i_clk, i_rst_n, w_cmd.post, o_valid)

endmodule
`default_nettype wire

[bench/urf_run_checker.sv]
// checker for the unsorted range finder: watches both channels, predicts each result word
// from the accepted input words and compares it field by field; depends on urf_pkg
module urf_run_checker #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int VALUE_BITS   = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [VALUE_BITS-1:0]           i_in_value,
    input  logic                            i_in_last,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_sorted,
    input  logic [urf_pkg::INDEX_BITS-1:0]  i_first,
    input  logic [urf_pkg::INDEX_BITS-1:0]  i_last,
    input  logic                            i_overflow,
    output int                              o_mismatches,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IB = urf_pkg::INDEX_BITS;

    typedef struct packed {
        logic          sorted;
        logic [IB-1:0] first_idx;
        logic [IB-1:0] last_idx;
        logic          ovf;
    } span_t;

    logic [VALUE_BITS-1:0] seq_mem [MAX_ELEMENTS];
    int unsigned           seq_len = 0;
    logic                  ovf_seen = 1'b0;
    span_t                 span_q [$];
    int                    mismatch_cnt = 0;

    function automatic span_t predict_span();
        span_t                 s;
        logic [VALUE_BITS-1:0] run_max;
        logic [VALUE_BITS-1:0] run_min;
        int                    i;
        bit                    found;
        s = '0;
        found = 1'b0;
        if (seq_len >= 2) begin
            run_max = seq_mem[0];
            for (i = 1; i < int'(seq_len); i++) begin
                if (seq_mem[i] < run_max) begin
                    s.last_idx = IB'(i);
                    found = 1'b1;
                end else begin
                    run_max = seq_mem[i];
                end
            end
            if (found) begin
                run_min = seq_mem[seq_len-1];
                for (i = int'(seq_len) - 2; i >= 0; i--) begin
                    if (seq_mem[i] > run_min) begin
                        s.first_idx = IB'(i);
                    end else begin
                        run_min = seq_mem[i];
                    end
                end
            end
        end
        s.sorted = !found;
        s.ovf    = ovf_seen;
        return s;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        span_t exp_s;
        if (!i_rst_n) begin
            seq_len  = 0;
            ovf_seen = 1'b0;
            span_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (span_q.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %0d %0d %0d %0d",
                             $time, i_sorted, i_first, i_last, i_overflow);
                    mismatch_cnt++;
                end else begin
                    exp_s = span_q.pop_front();
                    check_field("already_sorted", 32'(exp_s.sorted), 32'(i_sorted));
                    check_field("first_index", 32'(exp_s.first_idx), 32'(i_first));
                    check_field("last_index", 32'(exp_s.last_idx), 32'(i_last));
                    check_field("overflow", 32'(exp_s.ovf), 32'(i_overflow));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (seq_len < MAX_ELEMENTS) begin
                    seq_mem[seq_len] = i_in_value;
                    seq_len++;
                end else begin
                    ovf_seen = 1'b1;
                end
                if (i_in_last) begin
                    span_q.push_back(predict_span());
                    seq_len  = 0;
                    ovf_seen = 1'b0;
                end
            end
        end
        o_pending    <= span_q.size();
        o_mismatches <= mismatch_cnt;
    end

endmodule

[bench/tb_unsorted_range_finder.sv]
// testbench top for the unsorted range finder: clock, reset, directed and random sequences
// with random idling on both channels; depends on urf_pkg, the block and urf_run_checker
module tb_unsorted_range_finder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ELEMENTS = 4096;
    localparam int VALUE_BITS   = 20;
    localparam int IB           = urf_pkg::INDEX_BITS;
    localparam int RANDOM_WORDS = 1250;
    localparam int IDLE_LIMIT   = 20000;
    localparam logic [31:0] VALUE_MAX = (32'd1 << VALUE_BITS) - 1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [VALUE_BITS-1:0] i_value;
    logic                  i_last_item;
    logic                  o_valid;
    logic                  i_ready;
    logic                  o_already_sorted;
    logic [IB-1:0]         o_first_index;
    logic [IB-1:0]         o_last_index;
    logic                  o_overflow;

    int                    mismatches;
    int                    pending;
    int                    words_sent;
    logic [VALUE_BITS-1:0] run_vals [$];

    unsorted_range_finder #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_BITS   (VALUE_BITS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_value          (i_value),
        .i_last_item      (i_last_item),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_already_sorted (o_already_sorted),
        .o_first_index    (o_first_index),
        .o_last_index     (o_last_index),
        .o_overflow       (o_overflow)
    );

    urf_run_checker #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_BITS   (VALUE_BITS)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_value   (i_value),
        .i_in_last    (i_last_item),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_sorted     (o_already_sorted),
        .i_first      (o_first_index),
        .i_last       (o_last_index),
        .i_overflow   (o_overflow),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input logic [VALUE_BITS-1:0] v, input logic last, input bit burst);
        int gap;
        gap = burst ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_value     = v;
        i_last_item = last;
        words_sent++;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic play_run();
        bit burst;
        int i;
        burst = ($urandom_range(0, 4) == 0);
        for (i = 0; i < run_vals.size(); i++) begin
            send_word(run_vals[i], i == run_vals.size() - 1, burst);
        end
    endtask

    task automatic build_random_run();
        int          len;
        int          shape;
        int          i;
        int          j;
        int          k;
        int          step;
        logic [31:0] acc;
        logic [VALUE_BITS-1:0] tmp;
        run_vals.delete();
        shape = $urandom_range(0, 9);
        len = (shape == 9) ? $urandom_range(20, 64) : $urandom_range(1, 16);
        if (shape <= 1) begin
            for (i = 0; i < len; i++) run_vals.push_back(VALUE_BITS'($urandom));
        end else if (shape == 2) begin
            acc = ($urandom_range(0, 1) == 1) ? 32'($urandom_range(0, VALUE_MAX - 3)) : 32'd0;
            for (i = 0; i < len; i++) run_vals.push_back(VALUE_BITS'(acc + $urandom_range(0, 3)));
        end else begin
            step = ($urandom_range(0, 1) == 1) ? 3 : 60000;
            acc = ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom_range(0, VALUE_MAX));
            for (i = 0; i < len; i++) begin
                acc = acc + $urandom_range(0, step);
                if (acc > VALUE_MAX) acc = VALUE_MAX;
                run_vals.push_back(VALUE_BITS'(acc));
            end
            j = $urandom_range(0, len - 1);
            k = $urandom_range(0, len - 1);
            if (shape == 5 || shape == 6) begin
                tmp         = run_vals[j];
                run_vals[j] = run_vals[k];
                run_vals[k] = tmp;
            end else if (shape == 7) begin
                if (j > k) begin
                    i = j;
                    j = k;
                    k = i;
                end
                while (j < k) begin
                    tmp         = run_vals[j];
                    run_vals[j] = run_vals[k];
                    run_vals[k] = tmp;
                    j++;
                    k--;
                end
            end else if (shape >= 8) begin
                run_vals[j] = VALUE_BITS'($urandom);
            end
        end
    endtask

    // receiver: random stalls, occasional long stretches of steady ready
    initial begin
        int hold;
        int gap;
        hold    = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                hold = 0;
            end else if (hold > 0) begin
                hold--;
            end else if (i_ready) begin
                gap = pick_gap();
                if (gap > 0) begin
                    i_ready = 1'b0;
                    hold    = gap - 1;
                end
            end else begin
                i_ready = 1'b1;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(0, 6);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int i;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_value     = '0;
        i_last_item = 1'b0;
        words_sent  = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        run_vals = '{20'd0};
        play_run();
        run_vals = '{20'hFFFFF};
        play_run();
        run_vals = '{20'd0, 20'hFFFFF};
        play_run();
        run_vals = '{20'hFFFFF, 20'd0};
        play_run();
        run_vals = '{20'd5, 20'd5, 20'd5};
        play_run();
        run_vals = '{20'd1, 20'd3, 20'd2, 20'd4, 20'd5};
        play_run();
        run_vals = '{20'd9, 20'd7, 20'd5, 20'd3};
        play_run();
        run_vals = '{20'd2, 20'd6, 20'd4, 20'd8, 20'd10, 20'd9, 20'd15};
        play_run();

        i = words_sent;
        while (words_sent - i < RANDOM_WORDS) begin
            build_random_run();
            play_run();
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/urf_pkg.sv
hdl/urf_ram.sv
hdl/urf_ctrl.sv
hdl/urf_dp.sv
hdl/unsorted_range_finder.sv
bench/urf_run_checker.sv
bench/tb_unsorted_range_finder.sv
